@@ hw/rtl/uphr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uphr_pkg
// Types, round tables and helper functions shared by the 16-round unique ID
// hash pipeline.
// ----------------------------------------------------------------------------
package uphr_pkg;

    localparam int HashRounds = 16;
    localparam int UidWords   = 6;

    // Four 16-bit chaining words.
    typedef struct packed {
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        logic [15:0] d;
    } hash_state_t;

    // The six ID words, word 0 in the low slot.
    typedef logic [UidWords-1:0][15:0] uid_words_t;

    // Chaining word start values.
    localparam logic [15:0] InitA = 16'h2301;
    localparam logic [15:0] InitB = 16'hab89;
    localparam logic [15:0] InitC = 16'hdcfe;
    localparam logic [15:0] InitD = 16'h5476;

    // Per-round additive constants, round 15 first in the list, round 0 last.
    localparam logic [HashRounds-1:0][15:0] RoundAdd = {
        16'h7e82, 16'h7e4f, 16'h59c3, 16'h2244,
        16'hd039, 16'h7ec6, 16'hea44, 16'h3942,
        16'he905, 16'hcde6, 16'h105d, 16'h2562,
        16'h1122, 16'h98d8, 16'h0faf, 16'ha478
    };

    // Per-round left rotation amounts, round 15 first in the list, round 0 last.
    localparam logic [HashRounds-1:0][3:0] RoundRot = {
        4'd13, 4'd15, 4'd10, 4'd8,
        4'd3,  4'd0,  4'd11, 4'd4,
        4'd2,  4'd14, 4'd9,  4'd5,
        4'd6,  4'd1,  4'd12, 4'd7
    };

    // Index of the ID word that a round mixes in.
    function automatic logic [2:0] round_sel(input int round);
        int sel;
        begin
            if (round < 6) begin
                sel = round;
            end else if (round < 8) begin
                sel = (5 * round + 1) % 6;
            end else if (round < 12) begin
                sel = (3 * round + 5) % 6;
            end else begin
                sel = (2 * round) % 6;
            end
            return sel[2:0];
        end
    endfunction

    // Boolean mixing function of a round.
    function automatic logic [15:0] round_mix(input int round, input logic [15:0] b,
                                              input logic [15:0] c, input logic [15:0] d);
        logic [15:0] f;
        begin
            if (round < 6) begin
                f = (b & c) | (~b & d);
            end else if (round < 8) begin
                f = (b & d) | (c & ~d);
            end else if (round < 12) begin
                f = b ^ c ^ d;
            end else begin
                f = c ^ (b | ~d);
            end
            return f;
        end
    endfunction

    // 16-bit rotate left; an amount of zero returns the word unchanged.
    function automatic logic [15:0] rotl16(input logic [15:0] x, input logic [3:0] amt);
        logic [31:0] wide;
        begin
            wide = {x, x} << amt;
            return wide[31:16];
        end
    endfunction

endpackage

@@ hw/rtl/uphr_round.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uphr_round
// One hash round as one pipeline stage: mixes the chaining words, registers
// the result with its valid bit, and carries the ID words along.
// ----------------------------------------------------------------------------
module uphr_round
    import uphr_pkg::*;
#(
    parameter int ROUND = 0
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  hash_state_t in_state,
    input  uid_words_t  in_words,
    output logic        out_valid,
    input  logic        out_ready,
    output hash_state_t out_state,
    output uid_words_t  out_words
);

    localparam logic [2:0]  Sel = round_sel(ROUND);
    localparam logic [15:0] Add = RoundAdd[ROUND];
    localparam logic [3:0]  Rot = RoundRot[ROUND];

    logic        valid_reg;
    logic        valid_next;
    hash_state_t state_reg;
    hash_state_t state_next;
    uid_words_t  words_reg;
    logic [15:0] sum;
    logic        load;

    // The stage takes a new transaction when empty or when its content moves on.
    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // Round arithmetic, all modulo 2^16.
    always_comb begin
        sum = round_mix(ROUND, in_state.b, in_state.c, in_state.d)
            + in_state.a + Add + in_words[Sel];
        state_next.a = in_state.d;
        state_next.d = in_state.c;
        state_next.c = in_state.b;
        state_next.b = in_state.b + rotl16(sum, Rot);
        valid_next   = in_ready ? in_valid : valid_reg;
    end

    // Valid bit.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (load) begin
            state_reg <= state_next;
            words_reg <= in_words;
        end
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;
    assign out_words = words_reg;

endmodule

@@ hw/rtl/uid_pseudo_hash_16round_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uid_pseudo_hash_16round_unit
// Folds a 96-bit unique ID into a 64-bit hashed ID with 16 pipelined rounds.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (s_valid, s_ready) carries the six 16-bit ID words;
//   the result channel (m_valid, m_ready) returns the four hash words.
//   Every input transaction yields exactly one result transaction, in order.
//   Each of the 16 rounds is one register stage between acceptance and the
//   result showing on m_*. The pipeline accepts one transaction per cycle
//   while the receiver keeps m_ready high; one round's add-rotate-add path
//   sets the clock.
//   Each stage holds a valid bit; when the receiver stalls, full stages hold
//   their content and empty stages ahead of them still fill, so s_ready only
//   drops once every stage is full. s_ready then follows m_ready.
//   A synchronous low aresetn empties the pipeline; results in flight are
//   dropped and m_valid is low after reset.
// ----------------------------------------------------------------------------
module uid_pseudo_hash_16round_unit
    import uphr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_uid_word0,
    input  logic [15:0] s_uid_word1,
    input  logic [15:0] s_uid_word2,
    input  logic [15:0] s_uid_word3,
    input  logic [15:0] s_uid_word4,
    input  logic [15:0] s_uid_word5,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_hash_word0,
    output logic [15:0] m_hash_word1,
    output logic [15:0] m_hash_word2,
    output logic [15:0] m_hash_word3
);

    logic        valid_chain [HashRounds+1];
    logic        ready_chain [HashRounds+1];
    hash_state_t state_chain [HashRounds+1];
    uid_words_t  words_chain [HashRounds+1];

    // Pipeline entry: start values and the incoming ID.
    assign valid_chain[0] = s_valid;
    assign s_ready        = ready_chain[0];
    assign state_chain[0] = '{a: InitA, b: InitB, c: InitC, d: InitD};
    assign words_chain[0] = {s_uid_word5, s_uid_word4, s_uid_word3,
                             s_uid_word2, s_uid_word1, s_uid_word0};

    // One stage per round.
    for (genvar r = 0; r < HashRounds; r++) begin : g_round
        uphr_round #(
            .ROUND(r)
        ) u_round (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (valid_chain[r]),
            .in_ready  (ready_chain[r]),
            .in_state  (state_chain[r]),
            .in_words  (words_chain[r]),
            .out_valid (valid_chain[r+1]),
            .out_ready (ready_chain[r+1]),
            .out_state (state_chain[r+1]),
            .out_words (words_chain[r+1])
        );
    end

    // The last stage doubles as the output register.
    assign ready_chain[HashRounds] = m_ready;
    assign m_valid      = valid_chain[HashRounds];
    assign m_hash_word0 = state_chain[HashRounds].a;
    assign m_hash_word1 = state_chain[HashRounds].b;
    assign m_hash_word2 = state_chain[HashRounds].c;
    assign m_hash_word3 = state_chain[HashRounds].d;

endmodule

@@ hw/rtl/uphr_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uphr_checker
// Port-level checks for the unique ID hash pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module uphr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_hash_word0,
    input logic [15:0] m_hash_word1,
    input logic [15:0] m_hash_word2,
    input logic [15:0] m_hash_word3
);

    // Reset empties the pipeline.
    property p_reset_empty;
        @(posedge aclk) !aresetn |=> !m_valid;
    endproperty
    a_reset_empty: assert property (p_reset_empty)
        else $error("m_valid high after reset");

    // With the last stage empty, every stage can take a transaction.
    property p_ready_when_drained;
        @(posedge aclk) disable iff (!aresetn) !m_valid |-> s_ready;
    endproperty
    a_ready_when_drained: assert property (p_ready_when_drained)
        else $error("s_ready low while the output stage is empty");

    // A receiver that takes the result keeps the pipeline moving.
    property p_ready_follows_sink;
        @(posedge aclk) disable iff (!aresetn) m_ready |-> s_ready;
    endproperty
    a_ready_follows_sink: assert property (p_ready_follows_sink)
        else $error("s_ready low while m_ready is high");

    // A stalled result holds.
    property p_stall_hold;
        @(posedge aclk) disable iff (!aresetn)
            m_valid && !m_ready |=> m_valid && $stable(m_hash_word0)
                && $stable(m_hash_word1) && $stable(m_hash_word2)
                && $stable(m_hash_word3);
    endproperty
    a_stall_hold: assert property (p_stall_hold)
        else $error("result changed while stalled");

    // An offered input transaction stays offered until it is accepted.
    property p_input_hold;
        @(posedge aclk) disable iff (!aresetn) s_valid && !s_ready |=> s_valid;
    endproperty
    a_input_hold: assert property (p_input_hold)
        else $error("s_valid dropped before the transaction was accepted");

endmodule

bind uid_pseudo_hash_16round_unit uphr_checker u_uphr_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_hash_word0 (m_hash_word0),
    .m_hash_word1 (m_hash_word1),
    .m_hash_word2 (m_hash_word2),
    .m_hash_word3 (m_hash_word3)
);

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 16-round unique ID hash pipeline.
// A behavioral hash function predicts the four hash words of every accepted
// ID. A monitor compares each result transaction in order against the
// predictions. The stimulus runs directed corner IDs, random IDs with bursty
// stalls on both sides, a long receiver hold that fills the pipeline, more
// random IDs, and a final back-to-back stretch.
// ----------------------------------------------------------------------------
module tb;

    import uphr_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_WAIT  = 24;
    localparam int CYCLE_LIMIT = 200000;

    typedef logic [5:0][15:0] uid_t;
    typedef logic [3:0][15:0] hash_t;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_uid_word0 = '0;
    logic [15:0] s_uid_word1 = '0;
    logic [15:0] s_uid_word2 = '0;
    logic [15:0] s_uid_word3 = '0;
    logic [15:0] s_uid_word4 = '0;
    logic [15:0] s_uid_word5 = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_hash_word0;
    logic [15:0] m_hash_word1;
    logic [15:0] m_hash_word2;
    logic [15:0] m_hash_word3;

    hash_t hash_due[$];
    logic  idle_on       = 1'b0;
    int    hold_requests = 0;
    int    holds_done    = 0;
    int    ids_sent      = 0;
    int    hashes_seen   = 0;
    int    fail_count    = 0;
    int    input_stalls  = 0;
    int    cycle_count   = 0;

    uid_pseudo_hash_16round_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_uid_word0  (s_uid_word0),
        .s_uid_word1  (s_uid_word1),
        .s_uid_word2  (s_uid_word2),
        .s_uid_word3  (s_uid_word3),
        .s_uid_word4  (s_uid_word4),
        .s_uid_word5  (s_uid_word5),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hash_word0 (m_hash_word0),
        .m_hash_word1 (m_hash_word1),
        .m_hash_word2 (m_hash_word2),
        .m_hash_word3 (m_hash_word3)
    );

    // Free-running clock.
    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // Additive constant of each round.
    function automatic logic [15:0] round_const(input int r);
        case (r)
            0:  return 16'ha478;
            1:  return 16'h0faf;
            2:  return 16'h98d8;
            3:  return 16'h1122;
            4:  return 16'h2562;
            5:  return 16'h105d;
            6:  return 16'hcde6;
            7:  return 16'he905;
            8:  return 16'h3942;
            9:  return 16'hea44;
            10: return 16'h7ec6;
            11: return 16'hd039;
            12: return 16'h2244;
            13: return 16'h59c3;
            14: return 16'h7e4f;
            default: return 16'h7e82;
        endcase
    endfunction

    // Left rotation of each round; round 10 does not rotate at all.
    function automatic int round_shift(input int r);
        case (r)
            0:  return 7;
            1:  return 12;
            2:  return 1;
            3:  return 6;
            4:  return 5;
            5:  return 9;
            6:  return 14;
            7:  return 2;
            8:  return 4;
            9:  return 11;
            10: return 0;
            11: return 3;
            12: return 8;
            13: return 10;
            14: return 15;
            default: return 13;
        endcase
    endfunction

    // Hash of one ID: four chaining words through the sixteen rounds.
    function automatic hash_t hash_of_uid(input uid_t uid);
        logic [15:0] a, b, c, d, f, sum, rot;
        int          sel, amt;
        hash_t       h;
        a = 16'h2301;
        b = 16'hab89;
        c = 16'hdcfe;
        d = 16'h5476;
        for (int r = 0; r < 16; r++) begin
            if (r < 6) begin
                f   = (b & c) | (~b & d);
                sel = r;
            end else if (r < 8) begin
                f   = (b & d) | (c & ~d);
                sel = (5 * r + 1) % 6;
            end else if (r < 12) begin
                f   = b ^ c ^ d;
                sel = (3 * r + 5) % 6;
            end else begin
                f   = c ^ (b | ~d);
                sel = (2 * r) % 6;
            end
            sum = f + a + round_const(r) + uid[sel];
            amt = round_shift(r);
            rot = (amt == 0) ? sum : ((sum << amt) | (sum >> (16 - amt)));
            a = d;
            d = c;
            c = b;
            b = b + rot;
        end
        h[0] = a;
        h[1] = b;
        h[2] = c;
        h[3] = d;
        return h;
    endfunction

    // Random word, biased toward all-zero, all-one and single-bit values.
    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hffff;
            2:       return 16'h0001 << $urandom_range(0, 15);
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic uid_t rand_uid();
        uid_t u;
        for (int k = 0; k < 6; k++) begin
            u[k] = rand_word();
        end
        return u;
    endfunction

    // Offer one ID, optionally after an idle burst, and hold it until accepted.
    task automatic send_uid(input uid_t uid);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_uid_word0 <= uid[0];
        s_uid_word1 <= uid[1];
        s_uid_word2 <= uid[2];
        s_uid_word3 <= uid[3];
        s_uid_word4 <= uid[4];
        s_uid_word5 <= uid[5];
        do begin
            @(posedge aclk);
            if (!s_ready) begin
                input_stalls++;
            end
        end while (!s_ready);
        hash_due.push_back(hash_of_uid(uid));
        ids_sent++;
    endtask

    // Receiver: checks each result transaction, then decides the next m_ready.
    always @(posedge aclk) begin : result_check
        hash_t got;
        hash_t want;
        int    stall_left;
        int    hold_left;
        got = {m_hash_word3, m_hash_word2, m_hash_word1, m_hash_word0};
        if (aresetn && m_valid && m_ready) begin
            hashes_seen++;
            if (hash_due.size() == 0) begin
                $error("result transaction with no ID outstanding: %h", got);
                fail_count++;
            end else begin
                want = hash_due.pop_front();
                for (int k = 0; k < 4; k++) begin
                    if (got[k] !== want[k]) begin
                        $error("hash_word%0d expected %h actual %h", k, want[k], got[k]);
                        fail_count++;
                    end
                end
            end
        end

        // Long hold on request, otherwise random stall bursts while idling is on.
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (hold_requests != holds_done) begin
            m_ready    <= 1'b0;
            hold_left  = HOLD_CYCLES - 1;
            holds_done <= holds_done + 1;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            m_ready    <= 1'b0;
            stall_left = $urandom_range(1, 19) - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Corner IDs: all zero, all one, checkerboards, one word full, lowest bit or clear.
    task automatic test_corner_ids();
        uid_t u;
        send_uid('0);
        send_uid('1);
        send_uid({6{16'h5555}});
        send_uid({6{16'haaaa}});
        for (int k = 0; k < 6; k++) begin
            u    = '0;
            u[k] = 16'hffff;
            send_uid(u);
            u[k] = 16'h0001;
            send_uid(u);
            u    = '1;
            u[k] = 16'h0000;
            send_uid(u);
        end
    endtask

    // Random IDs; idling is on for two runs of fifty transactions, then off for one.
    task automatic test_random_ids(input int count);
        for (int n = 0; n < count; n++) begin
            if (n % 50 == 0) begin
                idle_on <= ((n / 50) % 3 != 2);
            end
            send_uid(rand_uid());
        end
    endtask

    // Receiver holds off while IDs keep coming, so the pipeline fills and
    // s_ready must drop.
    task automatic test_full_pipeline(input int count);
        idle_on       <= 1'b0;
        hold_requests <= hold_requests + 1;
        for (int n = 0; n < count; n++) begin
            send_uid(rand_uid());
        end
    endtask

    // Back-to-back stretch at full rate with no idling on either side.
    task automatic test_full_rate(input int count);
        idle_on <= 1'b0;
        for (int n = 0; n < count; n++) begin
            send_uid(rand_uid());
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_corner_ids();
        test_random_ids(340);
        test_full_pipeline(40);
        test_random_ids(40);
        test_full_rate(100);
        s_valid <= 1'b0;

        while (hash_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Hashed %0d unique IDs and checked %0d results, including corner IDs,",
                 ids_sent, hashes_seen);
        $display("random stalls, a long receiver hold (%0d input stall cycles) and full rate.",
                 input_stalls);
        if (fail_count == 0 && hash_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
